// ===== rtl/core/utf8_to_rtf_escaper_macros.svh =====
// assertion macros for the asserting file, utf8_to_rtf_escaper.sv
`ifndef UTF8_TO_RTF_ESCAPER_MACROS_SVH
`define UTF8_TO_RTF_ESCAPER_MACROS_SVH

// same-cycle implication
`define U2R_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U2R_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/u2r_pkg.sv =====
package u2r_pkg;

	localparam int JOB_DEPTH = 4;
	localparam int JOB_AW    = $clog2(JOB_DEPTH);
	localparam int DIGITS    = 5;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_RAW  = 3'd1;
	localparam logic [2:0] KIND_HEX  = 3'd2;
	localparam logic [2:0] KIND_PAR  = 3'd3;
	localparam logic [2:0] KIND_UNI  = 3'd4;

	localparam logic [7:0] CH_BSL    = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3f;

	localparam logic [15:0] RECIP_10 = 16'd52429;

	typedef struct packed {
		logic                   prefix;
		logic [2:0]             kind;
		logic [7:0]             val;
		logic [DIGITS-1:0][3:0] digits;
		logic [2:0]             ndig;
		logic                   fin;
		logic                   bad;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = 8'h7b;
			4'd1: c = CH_BSL;
			4'd2: c = 8'h72;
			4'd3: c = 8'h74;
			4'd4: c = 8'h66;
			4'd5: c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] par_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = CH_LF;
			4'd1: c = CH_CR;
			4'd2: c = CH_BSL;
			4'd3: c = 8'h70;
			4'd4: c = 8'h61;
			4'd5: c = 8'h72;
			4'd6: c = CH_SPACE;
			4'd7: c = CH_LF;
			4'd8: c = CH_CR;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hex_esc_char(input logic [7:0] v, input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = CH_BSL;
			2'd1: c = CH_QUOTE;
			2'd2: c = hex_char(v[7:4]);
			default: c = hex_char(v[3:0]);
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/u2r_front.sv =====
module u2r_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            opcode,
	input  logic [7:0]      in_byte,
	input  logic            final_byte,
	input  u2r_pkg::q_stat_t q_stat,
	output logic            push,
	output u2r_pkg::job_t   push_job
);
	import u2r_pkg::*;

	logic        prefix_sent_q;
	logic [20:0] acc_q;
	logic [2:0]  rem_q;
	logic [2:0]  len_q;
	logic        bad_q;

	logic        conv_busy_q;
	logic [2:0]  conv_cnt_q;
	logic [15:0] conv_v_q;
	job_t        conv_job_q;

	logic        accept;
	logic [2:0]  len_n;
	logic [20:0] acc_n;
	logic [2:0]  rem_n;
	logic        stray;
	logic        bad_set;
	logic [2:0]  kind;
	logic [7:0]  val;
	logic [2:0]  ndig;
	job_t        job_d;
	logic        nonempty;
	logic        conv_done;

	logic [31:0] prod;
	logic [12:0] quot;
	logic [15:0] ten_quot;
	logic [15:0] rem_v;

	assign in_ready = !conv_busy_q && !q_stat.full;
	assign accept   = in_valid && in_ready;

	// utf-8 decode
	always_comb begin
		stray   = 1'b0;
		bad_set = 1'b0;
		len_n   = len_q;
		acc_n   = acc_q;
		rem_n   = rem_q;
		kind    = KIND_NONE;
		val     = 8'h00;
		ndig    = 3'd3;
		if (rem_q == 3'd0) begin
			case (in_byte) inside
				[8'h00:8'h7f]: begin len_n = 3'd1; acc_n = {13'd0, in_byte}; end
				[8'h80:8'hbf]: begin len_n = 3'd1; acc_n = '0; stray = 1'b1; end
				[8'hc0:8'hdf]: begin len_n = 3'd2; acc_n = {16'd0, in_byte[4:0]}; end
				[8'he0:8'hef]: begin len_n = 3'd3; acc_n = {17'd0, in_byte[3:0]}; end
				[8'hf0:8'hf7]: begin len_n = 3'd4; acc_n = {18'd0, in_byte[2:0]}; end
				[8'hf8:8'hfb]: begin len_n = 3'd5; acc_n = {19'd0, in_byte[1:0]}; end
				[8'hfc:8'hfd]: begin len_n = 3'd6; acc_n = {20'd0, in_byte[0]}; end
				default: begin len_n = 3'd1; acc_n = '0; stray = 1'b1; end
			endcase
			rem_n = len_n - 3'd1;
		end else begin
			bad_set = (in_byte[7:6] != 2'b10);
			acc_n   = {acc_q[14:0], in_byte[5:0]};
			rem_n   = rem_q - 3'd1;
		end
		if (rem_n == 3'd0) begin
			if (stray || len_n >= 3'd5) begin
				bad_set = 1'b1;
				kind    = KIND_HEX;
				val     = CH_SPACE;
			end else if (|acc_n[20:16]) begin
				kind = KIND_HEX;
				val  = CH_SPACE;
			end else if (acc_n[15:0] == {8'd0, CH_LF}) begin
				kind = KIND_PAR;
			end else if (acc_n[15:8] == 8'd0) begin
				kind = KIND_HEX;
				val  = acc_n[7:0];
			end else begin
				kind = KIND_UNI;
				if (acc_n[15:0] >= 16'd10000) begin
					ndig = 3'd5;
				end else if (acc_n[15:0] >= 16'd1000) begin
					ndig = 3'd4;
				end
			end
		end else if (final_byte) begin
			bad_set = 1'b1;
		end
	end

	always_comb begin
		job_d        = '0;
		job_d.prefix = !prefix_sent_q;
		if (!opcode) begin
			job_d.kind = KIND_RAW;
			job_d.val  = in_byte;
		end else begin
			job_d.kind = kind;
			job_d.val  = val;
			job_d.ndig = ndig;
			job_d.fin  = final_byte;
			job_d.bad  = final_byte && (bad_q || bad_set);
		end
	end

	assign nonempty  = !prefix_sent_q || !opcode || kind != KIND_NONE || final_byte;
	assign conv_done = conv_busy_q && conv_cnt_q == 3'(DIGITS) && !q_stat.full;

	always_comb begin
		if (conv_done) begin
			push     = 1'b1;
			push_job = conv_job_q;
		end else begin
			push     = accept && nonempty && job_d.kind != KIND_UNI;
			push_job = job_d;
		end
	end

	// divide by ten through the reciprocal, one digit a cycle
	assign prod     = 32'(conv_v_q) * 32'(RECIP_10);
	assign quot     = prod[31:19];
	assign ten_quot = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem_v    = conv_v_q - ten_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_sent_q <= 1'b0;
			acc_q         <= '0;
			rem_q         <= '0;
			len_q         <= '0;
			bad_q         <= 1'b0;
		end else if (accept) begin
			if (!opcode) begin
				prefix_sent_q <= 1'b1;
			end else if (final_byte) begin
				prefix_sent_q <= 1'b0;
				acc_q         <= '0;
				rem_q         <= '0;
				len_q         <= '0;
				bad_q         <= 1'b0;
			end else begin
				prefix_sent_q <= 1'b1;
				acc_q         <= acc_n;
				rem_q         <= rem_n;
				len_q         <= len_n;
				bad_q         <= bad_q || bad_set;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_busy_q <= 1'b0;
			conv_cnt_q  <= '0;
		end else if (accept && push_job.kind == KIND_UNI && !conv_done) begin
			conv_busy_q <= 1'b1;
			conv_cnt_q  <= '0;
		end else if (conv_busy_q) begin
			if (conv_cnt_q != 3'(DIGITS)) begin
				conv_cnt_q <= conv_cnt_q + 3'd1;
			end else if (!q_stat.full) begin
				conv_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && job_d.kind == KIND_UNI) begin
			conv_v_q   <= acc_n[15:0];
			conv_job_q <= job_d;
		end else if (conv_busy_q && conv_cnt_q != 3'(DIGITS)) begin
			conv_v_q <= {3'd0, quot};
			for (int i = 0; i < DIGITS; i++) begin
				if (conv_cnt_q == 3'(i)) begin
					conv_job_q.digits[i] <= rem_v[3:0];
				end
			end
		end
	end

endmodule

// ===== rtl/core/u2r_queue.sv =====
module u2r_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2r_pkg::job_t    push_job,
	input  logic             pop,
	output u2r_pkg::job_t    pop_job,
	output u2r_pkg::q_stat_t q_stat
);
	import u2r_pkg::*;

	job_t              mem_q [JOB_DEPTH];
	logic [JOB_AW-1:0] wr_ptr_q;
	logic [JOB_AW-1:0] rd_ptr_q;
	logic [JOB_AW:0]   count_q;

	assign q_stat.full  = (count_q == (JOB_AW+1)'(JOB_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_job      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + JOB_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + JOB_AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + (JOB_AW+1)'(1);
				2'b01: count_q <= count_q - (JOB_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/core/u2r_back.sv =====
module u2r_back (
	input  logic             clk,
	input  logic             arst_n,
	input  u2r_pkg::q_stat_t q_stat,
	input  u2r_pkg::job_t    head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             run_end,
	output logic             message_end,
	output logic             bad_input
);
	import u2r_pkg::*;

	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_FIN  = 2'd2;

	logic       started_q;
	logic [1:0] phase_q;
	logic [3:0] cnt_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       message_end_q;
	logic       bad_input_q;

	logic       load;
	logic [1:0] phase;
	logic [1:0] next_phase;
	logic [3:0] cnt;
	logic [3:0] body_len;
	logic [3:0] phase_len;
	logic       last;
	logic       done;
	logic [7:0] byte_d;
	logic       mend_d;
	logic [3:0] dig_idx;
	logic [3:0] dig_val;
	logic [3:0] tail_k;

	assign load = !q_stat.empty && (!out_valid_q || out_ready);

	always_comb begin
		if (started_q) begin
			phase = phase_q;
		end else if (head.prefix) begin
			phase = PH_PRE;
		end else if (head.kind != KIND_NONE) begin
			phase = PH_BODY;
		end else begin
			phase = PH_FIN;
		end
	end

	assign cnt = started_q ? cnt_q : 4'd0;

	always_comb begin
		case (head.kind)
			KIND_RAW: body_len = 4'd1;
			KIND_HEX: body_len = 4'd4;
			KIND_PAR: body_len = 4'd9;
			KIND_UNI: body_len = 4'd6 + {1'b0, head.ndig};
			default:  body_len = 4'd0;
		endcase
	end

	always_comb begin
		case (phase)
			PH_PRE:  phase_len = 4'd6;
			PH_BODY: phase_len = body_len;
			default: phase_len = 4'd3;
		endcase
	end

	assign last = (cnt == phase_len - 4'd1);

	always_comb begin
		next_phase = PH_FIN;
		done       = 1'b0;
		case (phase)
			PH_PRE: begin
				next_phase = (head.kind != KIND_NONE) ? PH_BODY : PH_FIN;
				done       = last && head.kind == KIND_NONE && !head.fin;
			end
			PH_BODY: done = last && !head.fin;
			default: done = last;
		endcase
	end

	// decimal digits, most significant first
	assign dig_idx = {1'b0, head.ndig} + 4'd1 - cnt;
	assign tail_k  = cnt - 4'd2 - {1'b0, head.ndig};

	always_comb begin
		case (dig_idx)
			4'd0: dig_val = head.digits[0];
			4'd1: dig_val = head.digits[1];
			4'd2: dig_val = head.digits[2];
			4'd3: dig_val = head.digits[3];
			4'd4: dig_val = head.digits[4];
			default: dig_val = 4'd0;
		endcase
	end

	always_comb begin
		mend_d = 1'b0;
		byte_d = 8'h00;
		case (phase)
			PH_PRE: byte_d = prefix_char(cnt);
			PH_BODY: begin
				case (head.kind)
					KIND_RAW: byte_d = head.val;
					KIND_HEX: byte_d = hex_esc_char(head.val, cnt[1:0]);
					KIND_PAR: byte_d = par_char(cnt);
					default: begin
						if (cnt == 4'd0) begin
							byte_d = CH_BSL;
						end else if (cnt == 4'd1) begin
							byte_d = CH_U;
						end else if (cnt < 4'd2 + {1'b0, head.ndig}) begin
							byte_d = CH_ZERO + {4'd0, dig_val};
						end else begin
							byte_d = hex_esc_char(CH_QMARK, tail_k[1:0]);
						end
					end
				endcase
			end
			default: begin
				case (cnt)
					4'd0: byte_d = CH_LF;
					4'd1: byte_d = CH_CR;
					default: begin
						byte_d = CH_RBRACE;
						mend_d = 1'b1;
					end
				endcase
			end
		endcase
	end

	assign pop = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			phase_q     <= PH_PRE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (done) begin
				started_q <= 1'b0;
			end else if (last) begin
				started_q <= 1'b1;
				phase_q   <= next_phase;
				cnt_q     <= '0;
			end else begin
				started_q <= 1'b1;
				phase_q   <= phase;
				cnt_q     <= cnt + 4'd1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q    <= byte_d;
			run_end_q     <= done;
			message_end_q <= mend_d;
			bad_input_q   <= mend_d && head.bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_end     = run_end_q;
	assign message_end = message_end_q;
	assign bad_input   = bad_input_q;

endmodule

// ===== rtl/core/utf8_to_rtf_escaper.sv =====
// channel  direction  handshake             payload
// in       into block in_valid / in_ready   opcode, in_byte, final_byte
// out      from block out_valid / out_ready out_byte, run_end, message_end, bad_input
//
// one output byte per cycle while jobs are queued and out_ready is high; a request causes 0 to 20 output bytes
// a request that decodes to \u keeps the front busy for the divide-by-ten digit loop,
// overlapped with output of earlier requests through the four-entry job queue
// a request that causes no byte leaves the front in the cycle it is accepted
// reset is asynchronous, no clearing pass; in_ready drops when the queue is full or digits run
module utf8_to_rtf_escaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       message_end,
	output logic       bad_input
);
	import u2r_pkg::*;

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	job_t    push_job;
	job_t    head;

	u2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.q_stat     (q_stat),
		.push       (q_push),
		.push_job   (push_job)
	);

	u2r_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (head),
		.q_stat   (q_stat)
	);

	u2r_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.message_end (message_end),
		.bad_input   (bad_input)
	);

`include "utf8_to_rtf_escaper_macros.svh"

	`U2R_ASSERT_IMP(a_mend_run_end, out_valid && message_end, run_end, "message end not run end")
	`U2R_ASSERT_IMP(a_bad_mend, out_valid && bad_input, message_end, "bad input off message end")
	`U2R_ASSERT_IMP(a_mend_brace, out_valid && message_end, out_byte == CH_RBRACE, "no brace")
	`U2R_ASSERT_IMP(a_push_full, q_push, !q_stat.full, "push into full queue")
	`U2R_ASSERT_NXT(a_pop_run_end, q_pop, out_valid && run_end, "pop without run end")

endmodule

// ===== test/tb_utf8_to_rtf_escaper.sv =====
module tb_utf8_to_rtf_escaper;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NDIR        = 24;
	localparam int PHASE_ITEMS = 24;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       msg_end;
		logic       bad;
	} rtf_byte_t;

	typedef struct packed {
		logic       op;
		logic [7:0] b;
		logic       fin;
		logic       bad;
	} dir_row_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic       opcode      = 1'b0;
	logic [7:0] in_byte     = 8'h00;
	logic       final_byte  = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;
	logic       message_end;
	logic       bad_input;

	// decoder state of the predictor
	logic        pfx_done;
	logic [20:0] cp_acc;
	logic [2:0]  cont_left;
	logic [2:0]  seq_len;
	logic        bad_flag;

	rtf_byte_t item_bytes[$];
	rtf_byte_t rtf_due[$];
	rtf_byte_t want;

	int err_count     = 0;
	int requests_sent = 0;
	int bytes_checked = 0;
	int msgs_closed   = 0;
	int bad_msgs      = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles   = 0;

	// "-" means the row is checked against the predictor
	dir_row_t dir_rows [NDIR] = '{
		'{1'b0, 8'h41, 1'b0, 1'b0},
		'{1'b1, 8'h00, 1'b0, 1'b0},
		'{1'b1, 8'h7f, 1'b0, 1'b0},
		'{1'b1, 8'h0a, 1'b0, 1'b0},
		'{1'b1, 8'hc3, 1'b0, 1'b0},
		'{1'b1, 8'ha9, 1'b0, 1'b0},
		'{1'b1, 8'hc4, 1'b0, 1'b0},
		'{1'b1, 8'h80, 1'b0, 1'b0},
		'{1'b1, 8'hef, 1'b0, 1'b0},
		'{1'b1, 8'hbf, 1'b0, 1'b0},
		'{1'b1, 8'hbf, 1'b0, 1'b0},
		'{1'b1, 8'hf0, 1'b0, 1'b0},
		'{1'b1, 8'h9f, 1'b0, 1'b0},
		'{1'b1, 8'h98, 1'b0, 1'b0},
		'{1'b1, 8'h80, 1'b0, 1'b0},
		'{1'b1, 8'he2, 1'b0, 1'b0},
		'{1'b0, 8'hff, 1'b1, 1'b0},
		'{1'b1, 8'h82, 1'b0, 1'b0},
		'{1'b1, 8'hac, 1'b0, 1'b0},
		'{1'b1, 8'h80, 1'b0, 1'b0},
		'{1'b1, 8'hc3, 1'b0, 1'b0},
		'{1'b1, 8'h41, 1'b0, 1'b0},
		'{1'b1, 8'hfe, 1'b1, 1'b1},
		'{1'b1, 8'he2, 1'b1, 1'b1}
	};

	string dir_text [NDIR] = '{
		"{\\rtf1A",
		"\\'00",
		"\\'7f",
		"\012\015\\par \012\015",
		"",
		"-",
		"-",
		"-",
		"-",
		"-",
		"\\u65535\\'3f",
		"-",
		"-",
		"-",
		"\\'20",
		"-",
		"-",
		"-",
		"-",
		"\\'20",
		"-",
		"-",
		"\\'20\012\015}",
		"{\\rtf1\012\015}"
	};

	utf8_to_rtf_escaper u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.message_end(message_end),
		.bad_input  (bad_input)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
	endfunction

	task automatic emit(input logic [7:0] ch, input logic me, input logic bad);
		rtf_byte_t r;
		r.ch      = ch;
		r.run_end = 1'b0;
		r.msg_end = me;
		r.bad     = bad;
		item_bytes.push_back(r);
	endtask

	task automatic emit_text(input string s);
		for (int i = 0; i < s.len(); i++)
			emit(s[i], 1'b0, 1'b0);
	endtask

	task automatic emit_hex(input logic [7:0] v);
		emit(8'h5c, 1'b0, 1'b0);
		emit(8'h27, 1'b0, 1'b0);
		emit(nibble_char(v[7:4]), 1'b0, 1'b0);
		emit(nibble_char(v[3:0]), 1'b0, 1'b0);
	endtask

	task automatic emit_code_point(input logic [20:0] cp);
		logic [7:0]  digs[$];
		logic [20:0] v;
		v = (cp > 21'd65535) ? 21'h20 : cp;
		if (v == 21'h0a) begin
			emit_text("\012\015\\par \012\015");
		end else if (v < 21'd256) begin
			emit_hex(v[7:0]);
		end else begin
			emit(8'h5c, 1'b0, 1'b0);
			emit(8'h75, 1'b0, 1'b0);
			while (v != 0) begin
				digs.push_front(8'h30 + 8'(v % 10));
				v = v / 10;
			end
			foreach (digs[i])
				emit(digs[i], 1'b0, 1'b0);
			emit_hex(8'h3f);
		end
	endtask

	task automatic clear_decoder();
		pfx_done  = 1'b0;
		cp_acc    = '0;
		cont_left = '0;
		seq_len   = '0;
		bad_flag  = 1'b0;
	endtask

	// fills item_bytes with the rtf bytes one request causes
	task automatic escape_item(input logic op, input logic [7:0] b, input logic fin);
		logic stray;
		item_bytes.delete();
		stray = 1'b0;
		if (!pfx_done) begin
			emit_text("{\\rtf1");
			pfx_done = 1'b1;
		end
		if (!op) begin
			emit(b, 1'b0, 1'b0);
		end else begin
			if (cont_left == 0) begin
				if (b < 8'h80) begin
					seq_len = 3'd1; cp_acc = 21'(b);
				end else if (b < 8'hc0) begin
					seq_len = 3'd1; cp_acc = '0; stray = 1'b1;
				end else if (b < 8'he0) begin
					seq_len = 3'd2; cp_acc = 21'(b[4:0]);
				end else if (b < 8'hf0) begin
					seq_len = 3'd3; cp_acc = 21'(b[3:0]);
				end else if (b < 8'hf8) begin
					seq_len = 3'd4; cp_acc = 21'(b[2:0]);
				end else if (b < 8'hfc) begin
					seq_len = 3'd5; cp_acc = 21'(b[1:0]);
				end else if (b < 8'hfe) begin
					seq_len = 3'd6; cp_acc = 21'(b[0]);
				end else begin
					seq_len = 3'd1; cp_acc = '0; stray = 1'b1;
				end
				cont_left = seq_len - 3'd1;
			end else begin
				if (b[7:6] != 2'b10)
					bad_flag = 1'b1;
				cp_acc    = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 3'd1;
			end
			if (cont_left == 0) begin
				if (stray || seq_len >= 3'd5) begin
					bad_flag = 1'b1;
					emit_hex(8'h20);
				end else begin
					emit_code_point(cp_acc);
				end
			end else if (fin) begin
				bad_flag = 1'b1;
			end
			if (fin) begin
				emit(8'h0a, 1'b0, 1'b0);
				emit(8'h0d, 1'b0, 1'b0);
				emit(8'h7d, 1'b1, bad_flag);
				clear_decoder();
			end
		end
		if (item_bytes.size() > 0)
			item_bytes[item_bytes.size() - 1].run_end = 1'b1;
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer(input logic op, input logic [7:0] b, input logic fin,
			input string text);
		rtf_byte_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		opcode     = op;
		in_byte    = b;
		final_byte = fin;
		escape_item(op, b, fin);
		if (text == "-") begin
			foreach (item_bytes[i])
				rtf_due.push_back(item_bytes[i]);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				r.ch      = text[i];
				r.run_end = (i == text.len() - 1);
				r.msg_end = r.run_end && op && fin;
				r.bad     = 1'b0;
				rtf_due.push_back(r);
			end
		end
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_char();
		logic [7:0] seq[$];
		logic       op;
		logic       fin;
		logic       broken;
		int         k;
		int         n;
		int         cut;
		op     = 1'b1;
		broken = 1'b0;
		n      = 0;
		k      = $urandom_range(0, 99);
		if (k < 30) begin
			seq.push_back(($urandom_range(0, 4) == 0) ? 8'h0a : 8'($urandom_range(0, 127)));
		end else if (k < 45) begin
			seq.push_back(8'($urandom_range(8'hc0, 8'hdf))); n = 1;
		end else if (k < 60) begin
			seq.push_back(8'($urandom_range(8'he0, 8'hef))); n = 2;
		end else if (k < 70) begin
			seq.push_back(8'($urandom_range(8'hf0, 8'hf7))); n = 3;
		end else if (k < 74) begin
			seq.push_back(8'($urandom_range(8'hf8, 8'hfb))); n = 4;
		end else if (k < 77) begin
			seq.push_back(8'($urandom_range(8'hfc, 8'hfd))); n = 5;
		end else if (k < 81) begin
			if ($urandom_range(0, 3) == 0)
				seq.push_back(8'($urandom_range(8'hfe, 8'hff)));
			else
				seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
		end else if (k < 86) begin
			seq.push_back(8'($urandom_range(8'hc0, 8'hef)));
			n      = (seq[0] < 8'he0) ? 1 : 2;
			broken = 1'b1;
		end else if (k < 92) begin
			op = 1'b0;
			seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			seq.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < n; i++)
			seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
		if (broken) begin
			cut = $urandom_range(1, n);
			seq[cut] = 8'($urandom_range(0, 255));
			if (seq[cut][7:6] == 2'b10)
				seq[cut][6] = 1'b1;
		end
		fin = ($urandom_range(0, 9) == 0);
		if (!op)
			fin = 1'($urandom_range(0, 1));
		else if (fin && n > 0 && $urandom_range(0, 3) == 0) begin
			// end the message part way through the sequence
			cut = $urandom_range(1, n);
			seq = seq[0:cut - 1];
		end
		foreach (seq[i])
			offer(op, seq[i], (i == seq.size() - 1) ? fin : 1'b0, "-");
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (rtf_due.size() != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready = 1'b0;
			hold_cycles--;
		end else begin
			out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			bytes_checked++;
			if (rtf_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected output byte %h run_end %b message_end %b bad_input %b",
					$time, out_byte, run_end, message_end, bad_input);
			end else begin
				want = rtf_due.pop_front();
				if (out_byte !== want.ch) begin
					err_count++;
					$display("%0t: out_byte expected %h actual %h", $time, want.ch, out_byte);
				end
				if (run_end !== want.run_end) begin
					err_count++;
					$display("%0t: run_end expected %b actual %b", $time, want.run_end, run_end);
				end
				if (message_end !== want.msg_end) begin
					err_count++;
					$display("%0t: message_end expected %b actual %b", $time, want.msg_end,
						message_end);
				end
				if (bad_input !== want.bad) begin
					err_count++;
					$display("%0t: bad_input expected %b actual %b", $time, want.bad, bad_input);
				end
				if (want.msg_end) begin
					msgs_closed++;
					if (want.bad)
						bad_msgs++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run timed out with %0d output bytes outstanding", $time, rtf_due.size());
		$display("tb_utf8_to_rtf_escaper failed");
		$finish;
	end

	initial begin
		int target;
		clear_decoder();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NDIR; i++) begin
			offer(dir_rows[i].op, dir_rows[i].b, dir_rows[i].fin, dir_text[i]);
			// typed closing rows carry the bad flag on the brace
			if (dir_text[i] != "-" && dir_rows[i].op && dir_rows[i].fin)
				rtf_due[rtf_due.size() - 1].bad = dir_rows[i].bad;
		end
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			// receiver held off while requests keep coming, so the input backs up
			if (phase == 0)
				hold_cycles = 300;
			target = requests_sent + PHASE_ITEMS;
			while (requests_sent < target)
				send_char();
			wait_drained();
		end

		repeat (40) @(negedge clk);
		if (rtf_due.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected output bytes never arrived", $time, rtf_due.size());
		end
		$display("%0d requests sent, %0d output bytes checked, %0d errors", requests_sent,
			bytes_checked, err_count);
		$display("%0d messages closed, %0d of them flagged bad", msgs_closed, bad_msgs);
		if (err_count == 0)
			$display("tb_utf8_to_rtf_escaper passed");
		else
			$display("tb_utf8_to_rtf_escaper failed");
		$finish;
	end

endmodule

// ===== utf8_to_rtf_escaper.f =====
+incdir+rtl/core
rtl/core/u2r_pkg.sv
rtl/core/u2r_front.sv
rtl/core/u2r_queue.sv
rtl/core/u2r_back.sv
rtl/core/utf8_to_rtf_escaper.sv
test/tb_utf8_to_rtf_escaper.sv
